// ===== sv/assert_macros.svh =====
// Assertion macros shared by the grid proximity RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define GRP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define GRP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define GRP_ASSERT(lbl, clk, rst_n, prop, msg)
`define GRP_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== sv/grp_pkg.sv =====
package grp_pkg;

    // Default grid store size
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    // Field widths
    localparam int DIM_W   = 7;
    localparam int COORD_W = 6;
    localparam int PROX_W  = 6;
    localparam int STEP_W  = 8;

    // Largest proximity the result field carries
    localparam logic [PROX_W-1:0] PROX_MAX = 6'd63;

    // Configuration register indexes
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // Input command codes
    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // Classified command handed from front to back
    typedef struct packed {
        t_cmd               cmd;
        logic               in_grid;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               cell_set;
    } t_item;

    // Grid dimensions in use, already clamped
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_dims;

    // Back-end status seen by the front
    typedef struct packed {
        logic clearing;
    } t_eng_status;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CCHK,
        ST_PROBE,
        ST_EMIT
    } t_eng_state;

endpackage

// ===== sv/grp_fifo.sv =====
`include "assert_macros.svh"

module grp_fifo
    import grp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_valid
);

    t_item      r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;

    // Advance pointers and fill count
    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ i_pop;
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rptr];
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);

    `GRP_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop,
        "queue push while full")
    `GRP_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid,
        "queue pop while empty")

endmodule

// ===== sv/grp_front.sv =====
module grp_front
    import grp_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    input  logic [15:0]       i_data,
    input  logic              i_user,
    output logic              o_ready,
    input  t_eng_status       i_status,
    input  logic              i_fifo_full,
    output logic              o_push,
    output t_item             o_item,
    output t_dims             o_dims
);

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(64);
            r_height <= DIM_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GRID_WIDTH:  r_width  <= i_cfg_wdata;
                REG_GRID_HEIGHT: r_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp dimensions into 1..MAX
    always_comb begin
        priority if (r_width == '0) begin
            o_dims.width = DIM_W'(1);
        end else if (32'(r_width) > MAX_COLS) begin
            o_dims.width = DIM_W'(MAX_COLS);
        end else begin
            o_dims.width = r_width;
        end
        priority if (r_height == '0) begin
            o_dims.height = DIM_W'(1);
        end else if (32'(r_height) > MAX_ROWS) begin
            o_dims.height = DIM_W'(MAX_ROWS);
        end else begin
            o_dims.height = r_height;
        end
    end

    // Unpack the beat and classify against the grid in use
    assign col = i_data[5:0];
    assign row = i_data[11:6];

    always_comb begin
        o_item.cmd      = t_cmd'(i_user);
        o_item.col      = col;
        o_item.row      = row;
        o_item.cell_set = i_data[12];
        o_item.in_grid  = ({1'b0, col} < o_dims.width) && ({1'b0, row} < o_dims.height);
    end

    // Stall while the queue is full or the store is being cleared
    assign o_ready = !i_fifo_full && !i_status.clearing;
    assign o_push  = i_valid && o_ready;

endmodule

// ===== sv/grp_engine.sv =====
`include "assert_macros.svh"

module grp_engine
    import grp_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dims             i_dims,
    input  t_item             i_item,
    input  logic              i_item_valid,
    output logic              o_pop,
    output t_eng_status       o_status,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic [PROX_W-1:0] o_res_prox,
    output logic              o_res_oor
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [STEP_W-1:0] x,
                                                input logic [STEP_W-1:0] y);
        return AW'(32'(y) * 32'(MAX_COLS) + 32'(x));
    endfunction

    function automatic logic [PROX_W-1:0] sat_prox(input logic [STEP_W-1:0] s);
        return (s > STEP_W'(PROX_MAX)) ? PROX_MAX : s[PROX_W-1:0];
    endfunction

    // Occupancy store
    logic          r_mem [DEPTH];
    logic          r_rd_data;
    logic          mem_we;
    logic          mem_wd;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;

    // Sequencer state
    t_eng_state          r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [STEP_W-1:0]   r_x0, n_x0;
    logic [STEP_W-1:0]   r_y0, n_y0;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [2:0]          r_k, n_k;
    logic                r_chk_valid, n_chk_valid;
    logic [STEP_W-1:0]   r_chk_step, n_chk_step;
    logic [PROX_W-1:0]   r_prox, n_prox;
    logic                r_oor, n_oor;
    logic                r_out_valid, n_out_valid;
    logic [PROX_W-1:0]   r_out_prox, n_out_prox;
    logic                r_out_oor, n_out_oor;

    // Ray geometry for the current step
    logic [STEP_W-1:0] xm, xp, ym, yp, px, py;
    logic [STEP_W:0]   xsum, ysum;
    logic              step_oob;
    logic              out_free;

    always_comb begin
        xm       = r_x0 - r_step;
        xp       = r_x0 + r_step;
        ym       = r_y0 - r_step;
        yp       = r_y0 + r_step;
        xsum     = {1'b0, r_x0} + {1'b0, r_step};
        ysum     = {1'b0, r_y0} + {1'b0, r_step};
        step_oob = (r_step > r_x0) || (r_step > r_y0)
                || (xsum >= (STEP_W+1)'(i_dims.width))
                || (ysum >= (STEP_W+1)'(i_dims.height));
    end

    // Pick one of the eight neighbors at this step
    always_comb begin
        unique case (r_k)
            3'd0: begin px = xm;   py = ym;   end
            3'd1: begin px = xm;   py = r_y0; end
            3'd2: begin px = xm;   py = yp;   end
            3'd3: begin px = r_x0; py = ym;   end
            3'd4: begin px = r_x0; py = yp;   end
            3'd5: begin px = xp;   py = ym;   end
            3'd6: begin px = xp;   py = r_y0; end
            3'd7: begin px = xp;   py = yp;   end
            default: begin px = r_x0; py = r_y0; end
        endcase
    end

    assign out_free = !r_out_valid || i_res_ready;

    // Next state and memory control
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_x0        = r_x0;
        n_y0        = r_y0;
        n_step      = r_step;
        n_k         = r_k;
        n_chk_valid = 1'b0;
        n_chk_step  = r_chk_step;
        n_prox      = r_prox;
        n_oor       = r_oor;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out_prox  = r_out_prox;
        n_out_oor   = r_out_oor;
        mem_we      = 1'b0;
        mem_wd      = 1'b0;
        mem_wa      = r_clr;
        mem_ra      = cell_addr(px, py);
        o_pop       = 1'b0;

        unique case (r_state)
            // Sweep the store to zero after reset
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            // Take the next command from the queue
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop = 1'b1;
                    n_x0  = STEP_W'(i_item.col);
                    n_y0  = STEP_W'(i_item.row);
                    mem_ra = cell_addr(STEP_W'(i_item.col), STEP_W'(i_item.row));
                    if (i_item.cmd == CMD_WRITE) begin
                        mem_we = i_item.in_grid;
                        mem_wd = i_item.cell_set;
                        mem_wa = cell_addr(STEP_W'(i_item.col), STEP_W'(i_item.row));
                    end else if (!i_item.in_grid) begin
                        n_prox  = '0;
                        n_oor   = 1'b1;
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_CCHK;
                    end
                end
            end
            // Check the queried cell itself
            ST_CCHK: begin
                n_oor = 1'b0;
                if (!r_rd_data) begin
                    n_prox  = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_step  = STEP_W'(1);
                    n_k     = 3'd0;
                    n_state = ST_PROBE;
                end
            end
            // Issue one neighbor read per cycle, check the one before
            ST_PROBE: begin
                if (r_chk_valid && !r_rd_data) begin
                    n_prox  = sat_prox(r_chk_step);
                    n_state = ST_EMIT;
                end else if (r_k == 3'd0 && step_oob) begin
                    n_prox  = sat_prox(r_step);
                    n_state = ST_EMIT;
                end else begin
                    n_chk_valid = 1'b1;
                    n_chk_step  = r_step;
                    n_k         = r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        n_step = r_step + STEP_W'(1);
                    end
                end
            end
            // Hand the result to the output register
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_prox  = r_prox;
                    n_out_oor   = r_oor;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x0       <= n_x0;
        r_y0       <= n_y0;
        r_step     <= n_step;
        r_k        <= n_k;
        r_chk_step <= n_chk_step;
        r_prox     <= n_prox;
        r_oor      <= n_oor;
        r_out_prox <= n_out_prox;
        r_out_oor  <= n_out_oor;
    end

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_res_valid       = r_out_valid;
    assign o_res_prox        = r_out_prox;
    assign o_res_oor         = r_out_oor;

    `GRP_ASSERT(a_result_from_emit, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state == ST_EMIT), "result not from emit state")
    `GRP_ASSERT(a_probe_step_nonzero, i_clk, i_rst_n,
        (r_state == ST_PROBE) |-> (r_step != '0), "probe with zero step")
    `GRP_ASSERT_NEVER(a_no_pop_when_busy, i_clk, i_rst_n,
        o_pop && (r_state != ST_IDLE), "command taken while busy")

endmodule

// ===== sv/grid_ray_proximity.sv =====
// Binary occupancy grid with a ray proximity query. Items arrive on the
// slave stream (tuser = cmd, tdata = col, row, cell_set) and pass through a
// two-entry queue to a sequencer that owns a one-bit-per-cell store with one
// write and one registered read port. A write is handled in the idle state and
// produces no beat. A query outside the grid goes from idle straight to emit
// with out_of_range set. A query on an unset cell goes through the cell check
// to emit. A query on a set cell probes ray steps outward: each ray step
// reads the eight neighbors one per cycle through the single read port, and
// a step that reaches the border ends the search without reads. After reset
// the store is cleared one cell per cycle (MAX_COLS*MAX_ROWS cells, 4096
// by default) while the slave tready stays low; configuration writes are
// taken at any time.
module grid_ray_proximity
    import grp_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_wdata,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [15:0]       i_s_axis_tdata,  // col[5:0], row[11:6], cell_set[12]
    input  logic              i_s_axis_tuser,  // cmd[0]
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,  // proximity[5:0]
    output logic              o_m_axis_tuser   // out_of_range[0]
);

    t_item       push_item;
    t_item       pop_item;
    t_dims       dims;
    t_eng_status status;
    logic        push;
    logic        pop;
    logic        fifo_full;
    logic        fifo_valid;
    logic [PROX_W-1:0] res_prox;

    grp_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .i_data      (i_s_axis_tdata),
        .i_user      (i_s_axis_tuser),
        .o_ready     (o_s_axis_tready),
        .i_status    (status),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_item      (push_item),
        .o_dims      (dims)
    );

    grp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_full  (fifo_full),
        .o_valid (fifo_valid)
    );

    grp_engine #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dims       (dims),
        .i_item       (pop_item),
        .i_item_valid (fifo_valid),
        .o_pop        (pop),
        .o_status     (status),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res_prox   (res_prox),
        .o_res_oor    (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {2'b00, res_prox};

endmodule
